// ===== hdl/lrq_pkg.sv =====
// Shared types and constants for the lossy ring queue.
package lrq_pkg;

	// Width of the data and count fields on the ports
	localparam int ITEM_W = 32;

	// Request opcodes
	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_t;

	// One decoded request passed from the front queue to the back end
	typedef struct packed {
		cmd_t              cmd;
		logic [ITEM_W-1:0] data;
	} req_t;

endpackage

// ===== hdl/lrq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lrq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/lrq_front.sv =====
// Front end: accepts requests, decodes the command and buffers them in a two-entry queue.
module lrq_front
	import lrq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              command,
	input  logic [ITEM_W-1:0] item_data,
	output logic              req_valid,
	output req_t              req,
	input  logic              req_take
);

	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	req_t       entry_q [2];
	req_t       new_req;
	logic       push;

	// Stall only when both entries are occupied
	assign in_stall  = count_q[1];
	assign push      = in_valid && !in_stall;
	assign req_valid = (count_q != 2'd0);
	assign req       = entry_q[rd_ptr_q];

	// Decode the incoming request
	always_comb begin
		new_req.cmd  = cmd_t'(command);
		new_req.data = item_data;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (req_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, req_take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the request payload
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_req;
		end
	end

endmodule

// ===== hdl/lrq_back.sv =====
// Back end: runs requests against the counters and ring RAM and holds the result register.
module lrq_back
	import lrq_pkg::*;
#(
	parameter int DEPTH       = 16,
	parameter int DATA_WIDTH  = 32,
	parameter int COUNT_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  req_t              req,
	output logic              req_take,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              data_valid,
	output logic [ITEM_W-1:0] read_data,
	output logic [ITEM_W-1:0] dropped_count,
	output logic              queue_empty
);

	localparam int SLOT_W = $clog2(DEPTH);
	localparam int CMP_W  = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
	localparam logic [COUNT_WIDTH-1:0] CNT_LAST = '1;
	localparam logic [COUNT_WIDTH-1:0] READABLE = COUNT_WIDTH'(DEPTH - 1);
	// Oldest readable position sits DEPTH-1 behind the write counter
	localparam logic [COUNT_WIDTH-1:0] LOW_RST  = COUNT_WIDTH'(0) - READABLE;
	localparam longint unsigned LOW_WIDE   = 64'(LOW_RST);
	localparam longint unsigned DEPTH_WIDE = 64'(DEPTH);
	localparam logic [SLOT_W-1:0] LOW_SLOT_RST = SLOT_W'(LOW_WIDE % DEPTH_WIDE);
	localparam logic [SLOT_W-1:0] SLOT_LAST    = SLOT_W'(DEPTH - 1);

	// Next value of (cnt mod DEPTH) after cnt increments with wrap
	function automatic logic [SLOT_W-1:0] slot_inc(input logic [COUNT_WIDTH-1:0] cnt,
		input logic [SLOT_W-1:0] slot);
		if (cnt == CNT_LAST || slot == SLOT_LAST) begin
			return '0;
		end
		return slot + 1'b1;
	endfunction

	logic [COUNT_WIDTH-1:0] sent_q, taken_q, low_q;
	logic [SLOT_W-1:0]      sent_slot_q, taken_slot_q, low_slot_q;
	logic [COUNT_WIDTH-1:0] sent_nxt, taken_nxt, low_nxt;
	logic [SLOT_W-1:0]      sent_slot_nxt, taken_slot_nxt, low_slot_nxt;

	logic                   valid_s1, hit_s1, empty_s1;
	logic [COUNT_WIDTH-1:0] dropped_s1;

	logic                   out_valid_q, data_valid_q, empty_q;
	logic [ITEM_W-1:0]      read_data_q, dropped_q;

	logic                   s1_move, issue, is_enq, has_item, overrun, hit;
	logic [COUNT_WIDTH-1:0] pending, drop_amt;
	logic [SLOT_W-1:0]      rd_addr;
	logic [DATA_WIDTH-1:0]  rd_data;
	logic                   ram_we, ram_re;

	// Issue a request only when the result stage frees up
	assign s1_move  = valid_s1 && (!out_valid_q || !out_stall);
	assign issue    = req_valid && (!valid_s1 || s1_move);
	assign req_take = issue;
	assign is_enq   = (req.cmd == CMD_ENQ);

	// Classify the dequeue
	assign pending  = sent_q - taken_q;
	assign has_item = (pending != '0);
	assign overrun  = (CMP_W'(pending) > CMP_W'(DEPTH - 1));
	assign drop_amt = overrun ? (pending - READABLE) : '0;

	// Compute next counter and slot values
	always_comb begin
		sent_nxt       = sent_q;
		sent_slot_nxt  = sent_slot_q;
		low_nxt        = low_q;
		low_slot_nxt   = low_slot_q;
		taken_nxt      = taken_q;
		taken_slot_nxt = taken_slot_q;
		rd_addr        = taken_slot_q;
		hit            = 1'b0;
		if (is_enq) begin
			sent_nxt      = sent_q + 1'b1;
			sent_slot_nxt = slot_inc(sent_q, sent_slot_q);
			low_nxt       = low_q + 1'b1;
			low_slot_nxt  = slot_inc(low_q, low_slot_q);
		end else if (has_item) begin
			hit = 1'b1;
			if (overrun) begin
				// Skip to the oldest readable item
				rd_addr        = low_slot_q;
				taken_nxt      = low_q + 1'b1;
				taken_slot_nxt = slot_inc(low_q, low_slot_q);
			end else begin
				taken_nxt      = taken_q + 1'b1;
				taken_slot_nxt = slot_inc(taken_q, taken_slot_q);
			end
		end
	end

	assign ram_we = issue && is_enq;
	assign ram_re = issue && hit;

	lrq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (sent_slot_q),
		.wr_data (DATA_WIDTH'(req.data)),
		.re      (ram_re),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Hold counters, result stage and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q       <= '0;
			sent_slot_q  <= '0;
			taken_q      <= '0;
			taken_slot_q <= '0;
			low_q        <= LOW_RST;
			low_slot_q   <= LOW_SLOT_RST;
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (issue) begin
				sent_q       <= sent_nxt;
				sent_slot_q  <= sent_slot_nxt;
				taken_q      <= taken_nxt;
				taken_slot_q <= taken_slot_nxt;
				low_q        <= low_nxt;
				low_slot_q   <= low_slot_nxt;
				valid_s1     <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the result payload
	always_ff @(posedge clk) begin
		if (issue) begin
			hit_s1     <= hit;
			dropped_s1 <= hit ? drop_amt : '0;
			empty_s1   <= (sent_nxt == taken_nxt);
		end
		if (s1_move) begin
			data_valid_q <= hit_s1;
			read_data_q  <= hit_s1 ? ITEM_W'(rd_data) : '0;
			dropped_q    <= ITEM_W'(dropped_s1);
			empty_q      <= empty_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign data_valid    = data_valid_q;
	assign read_data     = read_data_q;
	assign dropped_count = dropped_q;
	assign queue_empty   = empty_q;

endmodule

// ===== hdl/lossy_ring_queue_drop_count.sv =====
// Top level of the lossy ring queue with drop count.
//
// Each request (enqueue or dequeue) yields exactly one result, in order. The block
// takes one request per clock when the output side does not stall: the back end
// makes one access to the ring RAM per cycle, which sets that rate. The request
// passes through the front queue, then the result stage with the registered RAM
// read, then the output register. Enqueues never block on a full ring; a dequeue
// that finds more than DEPTH-1 pending items skips the oldest ones and reports
// how many in dropped_count. Only DEPTH-1 items are readable back. A dequeue of
// a slot that was never written returns undefined data.
module lossy_ring_queue_drop_count
	import lrq_pkg::*;
#(
	parameter int DEPTH       = 16,
	parameter int DATA_WIDTH  = 32,
	parameter int COUNT_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              command,
	input  logic [ITEM_W-1:0] item_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              data_valid,
	output logic [ITEM_W-1:0] read_data,
	output logic [ITEM_W-1:0] dropped_count,
	output logic              queue_empty
);

	logic req_valid;
	logic req_take;
	req_t req;

	lrq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.item_data (item_data),
		.req_valid (req_valid),
		.req       (req),
		.req_take  (req_take)
	);

	lrq_back #(
		.DEPTH       (DEPTH),
		.DATA_WIDTH  (DATA_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req           (req),
		.req_take      (req_take),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.data_valid    (data_valid),
		.read_data     (read_data),
		.dropped_count (dropped_count),
		.queue_empty   (queue_empty)
	);

endmodule

// ===== hdl/lrq_checker.sv =====
// Port-level checks for the lossy ring queue, bound to the top level.
module lrq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        data_valid,
	input logic [31:0] read_data,
	input logic [31:0] dropped_count,
	input logic        queue_empty
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(data_valid) && $stable(read_data)
			&& $stable(dropped_count) && $stable(queue_empty))
		else $error("stalled result changed");

	// Results without an item carry zero data and no drops
	a_no_item_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_valid |-> read_data == 32'd0 && dropped_count == 32'd0)
		else $error("non-item result carries data");

	// Drops are only reported alongside a returned item
	a_drop_with_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped_count != 32'd0 |-> data_valid)
		else $error("drop count without item");

endmodule

bind lossy_ring_queue_drop_count lrq_checker u_lrq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.data_valid    (data_valid),
	.read_data     (read_data),
	.dropped_count (dropped_count),
	.queue_empty   (queue_empty)
);

// ===== tb/lrq_result_checker.sv =====
// Request/result monitor for the lossy ring queue: predicts each result and compares it.
module lrq_result_checker
	import lrq_pkg::*;
#(
	parameter int DEPTH       = 16,
	parameter int DATA_WIDTH  = 32,
	parameter int COUNT_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              command,
	input  logic [ITEM_W-1:0] item_data,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              data_valid,
	input  logic [ITEM_W-1:0] read_data,
	input  logic [ITEM_W-1:0] dropped_count,
	input  logic              queue_empty,
	output int                fail_count,
	output int                pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ITEM_W-1:0] DATA_MASK = {ITEM_W{1'b1}} >> (ITEM_W - DATA_WIDTH);

	// One predicted result, in port order
	typedef struct packed {
		logic              got_item;
		logic [ITEM_W-1:0] item;
		logic [ITEM_W-1:0] skipped;
		logic              empty;
	} ring_result_t;

	// Shadow copy of the ring and its two wrapping counters
	logic [ITEM_W-1:0]      ring_mem [DEPTH];
	logic [COUNT_WIDTH-1:0] write_count;
	logic [COUNT_WIDTH-1:0] read_count;

	ring_result_t results_due[$];
	ring_result_t oldest_due;
	int unsigned  issued;
	int unsigned  retired;

	assign pending_results = issued - retired;

	// Apply one request to the shadow ring and return the result it must produce
	function automatic ring_result_t apply_request(input cmd_t op,
	                                               input logic [ITEM_W-1:0] word);
		ring_result_t           res;
		logic [COUNT_WIDTH-1:0] backlog;
		logic [COUNT_WIDTH-1:0] overrun;
		res = '0;
		if (op == CMD_ENQ) begin
			ring_mem[write_count % DEPTH] = word & DATA_MASK;
			write_count = write_count + 1'b1;
		end else begin
			backlog = write_count - read_count;
			if (backlog != '0) begin
				// skip whatever the writer has already lapped
				overrun = (backlog > DEPTH - 1) ? backlog - (DEPTH - 1) : '0;
				read_count = read_count + overrun + 1'b1;
				res.got_item = 1'b1;
				res.item     = ring_mem[(read_count - 1'b1) % DEPTH];
				res.skipped  = overrun;
			end
		end
		res.empty = (write_count == read_count);
		return res;
	endfunction

	function automatic void check_field(input string field_name,
	                                    input logic [ITEM_W-1:0] want,
	                                    input logic [ITEM_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field_name, want, got);
			fail_count++;
		end
	endfunction

	// Predict on every accepted request, compare on every accepted result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_count = '0;
			read_count  = '0;
			results_due.delete();
			issued      = 0;
			retired     = 0;
			fail_count  = 0;
		end else begin
			if (in_valid && !in_stall) begin
				results_due.push_back(apply_request(cmd_t'(command), item_data));
				issued++;
			end
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$error("result with no request pending: data_valid %0d read_data 0x%0h",
					       data_valid, read_data);
					fail_count++;
				end else begin
					oldest_due = results_due.pop_front();
					retired++;
					check_field("data_valid", oldest_due.got_item, data_valid);
					check_field("read_data", oldest_due.item, read_data);
					check_field("dropped_count", oldest_due.skipped, dropped_count);
					check_field("queue_empty", oldest_due.empty, queue_empty);
				end
			end
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Stimulus, flow control and verdict for the lossy ring queue testbench.
module tb_top
	import lrq_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_REQUESTS = 550;
	localparam int PHASE_LEN       = 40;
	localparam int LONG_HOLD       = 100;
	localparam int DRAIN_CYCLES    = 8;
	localparam int RUN_LIMIT       = 200000;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic              command   = 1'b0;
	logic [ITEM_W-1:0] item_data = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              data_valid;
	logic [ITEM_W-1:0] read_data;
	logic [ITEM_W-1:0] dropped_count;
	logic              queue_empty;

	int fail_count;
	int pending_results;
	int accepted_requests = 0;
	int cycle_count = 0;

	lossy_ring_queue_drop_count dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.item_data     (item_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.data_valid    (data_valid),
		.read_data     (read_data),
		.dropped_count (dropped_count),
		.queue_empty   (queue_empty)
	);

	lrq_result_checker result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.item_data       (item_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.data_valid      (data_valid),
		.read_data       (read_data),
		.dropped_count   (dropped_count),
		.queue_empty     (queue_empty),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Bound the run
	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Offer one request and hold it until the block takes it
	task automatic send_request(input cmd_t op, input logic [ITEM_W-1:0] word);
		in_valid  <= 1'b1;
		command   <= op;
		item_data <= word;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		accepted_requests++;
	endtask

	task automatic idle_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Drop valid and hold until every outstanding result has come back
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending_results == 0);
	endtask

	// Receiver: one long hold-off once traffic is flowing, otherwise random stall patterns
	initial begin
		int  stall_mode;
		int  span;
		bit  held_off;
		held_off = 1'b0;
		wait (arst_n);
		forever begin
			if (!held_off && accepted_requests >= 120) begin
				held_off = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
			stall_mode = $urandom_range(0, 2);
			span       = $urandom_range(5, 40);
			repeat (span) begin
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Sender: reset, directed cases, then biased random phases
	initial begin
		cmd_t op;
		int   enq_pct;
		int   burst_len;
		int   sent_random;
		bit   paused;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// dequeue on an empty ring, data extremes, read back to empty
		send_request(CMD_DEQ, $urandom);
		send_request(CMD_ENQ, 32'h0000_0000);
		send_request(CMD_ENQ, 32'hFFFF_FFFF);
		send_request(CMD_DEQ, $urandom);
		send_request(CMD_DEQ, $urandom);
		send_request(CMD_DEQ, $urandom);
		idle_sender(2);

		// fill one past the readable depth so the next dequeue skips the oldest
		for (int i = 0; i < 16; i++) begin
			if (i == 0)
				send_request(CMD_ENQ, 32'hAAAA_AAAA);
			else if (i == 1)
				send_request(CMD_ENQ, 32'h5555_5555);
			else
				send_request(CMD_ENQ, $urandom);
		end
		send_request(CMD_DEQ, $urandom);
		idle_sender(1);

		// random phases that lean toward writing (overrun) or reading (empty)
		sent_random = 0;
		paused      = 1'b0;
		enq_pct     = 50;
		while (sent_random < RANDOM_REQUESTS) begin
			if (sent_random % PHASE_LEN == 0) begin
				case ($urandom_range(0, 2))
					0: enq_pct = 10;
					1: enq_pct = 50;
					default: enq_pct = 90;
				endcase
			end
			if (!paused && sent_random >= RANDOM_REQUESTS / 2) begin
				paused = 1'b1;
				wait_for_drain();
			end
			burst_len = $urandom_range(1, 12);
			for (int i = 0; i < burst_len; i++) begin
				op = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
				send_request(op, $urandom);
				sent_random++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_sender($urandom_range(1, 6));
		end

		// Finish: drain, let late results surface, give the verdict
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/lrq_pkg.sv
hdl/lrq_ram.sv
hdl/lrq_front.sv
hdl/lrq_back.sv
hdl/lossy_ring_queue_drop_count.sv
hdl/lrq_checker.sv
tb/lrq_result_checker.sv
tb/tb_top.sv
